### hdl/rls_arx_pkg.sv
`default_nettype none

package rls_arx_pkg;

    localparam int NB_DEF            = 4;
    localparam int NA_DEF            = 4;
    localparam int MAX_DEAD_TIME_DEF = 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FORGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COEF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV  = 2'd3;

    localparam logic [16:0]        FORGET_RST    = 17'd65536;
    localparam logic [3:0]         DEAD_TIME_RST = 4'd1;
    localparam logic signed [31:0] INIT_COEF_RST = 32'sd58982;
    localparam logic [30:0]        INIT_COV_RST  = 31'd65536000;

    typedef struct packed {
        logic signed [31:0] u_sample;
        logic signed [31:0] y_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pred_error;
        logic               last_coef;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Q16.16 product rounding: add half LSB, floor shift
    function automatic logic signed [63:0] qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s >>> 16;
    endfunction

endpackage

`default_nettype wire

### hdl/rls_arx_identifier_core.sv
// Channel   Dir  Handshake                    Payload
// in        in   i_in_valid / o_in_ready      i_in  (t_in_item: u_sample, y_sample)
// out       out  o_out_valid / i_out_ready    o_out (t_out_item: one coefficient)
// cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// Each item is processed in full before the next is accepted; it then gives N results, N = NB+NA.
// The covariance update uses the 1 bit/cycle divider: two 64-step divisions per covariance entry.
// All other products are 32x32 multiplies, formed in S_MUL and in S_KMUL.
// After reset and after each init_cov write a clearing pass reloads the covariance
// memory; no item is accepted during it. Synchronous active-low reset.
`default_nettype none

module rls_arx_identifier_core
    import rls_arx_pkg::*;
#(
    parameter int NB            = NB_DEF,
    parameter int NA            = NA_DEF,
    parameter int MAX_DEAD_TIME = MAX_DEAD_TIME_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  t_in_item              i_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output t_out_item                   o_out,
    input  wire                         i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int NPAR     = NB + NA;
    localparam int IN_DEPTH = NB + MAX_DEAD_TIME;
    localparam int HW       = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int IW       = $clog2(NPAR);
    localparam int AW       = $clog2(NPAR * NPAR);
    localparam logic [IW-1:0] LAST = IW'(NPAR - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PHI   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SUB   = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_KMUL  = 4'd9;
    localparam logic [3:0] S_KUPD  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    localparam logic [2:0] PH_EPS = 3'd0;
    localparam logic [2:0] PH_C   = 3'd1;
    localparam logic [2:0] PH_R   = 3'd2;
    localparam logic [2:0] PH_DEN = 3'd3;
    localparam logic [2:0] PH_UPD = 3'd4;
    localparam logic [2:0] PH_K   = 3'd5;

    logic [3:0]         r_state;
    logic [2:0]         r_ph;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;

    logic [16:0]        r_forget;
    logic [3:0]         r_dead;
    logic signed [31:0] r_init_coef;
    logic [30:0]        r_init_cov;

    logic signed [31:0] r_hist_u [IN_DEPTH];
    logic signed [31:0] r_hist_y [NA];
    logic signed [31:0] r_coef   [NPAR];
    logic signed [31:0] r_phi    [NPAR];
    logic signed [31:0] r_c      [NPAR];
    logic signed [31:0] r_r      [NPAR];
    logic signed [31:0] r_y;
    logic signed [31:0] r_eps;
    logic signed [31:0] r_den;
    logic signed [31:0] r_k;
    logic signed [31:0] r_pold;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_q;

    logic [31:0]        r_pmem [NPAR*NPAR];
    logic signed [31:0] r_pdat;

    logic [63:0]        r_dq;
    logic [31:0]        r_dr;
    logic [31:0]        r_dd;
    logic               r_dneg;
    logic [5:0]         r_dcnt;
    logic               r_dsec;

    logic [16:0]        w_lam;
    logic [IW-1:0]      w_row;
    logic [IW-1:0]      w_col;
    logic [31:0]        w_lin;
    logic [AW-1:0]      w_addr;
    logic               w_we;
    logic [31:0]        w_wdata;
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_acc_n;
    logic [32:0]        w_dt;
    logic               w_dge;
    logic [32:0]        w_dr_n;
    logic [63:0]        w_dq_n;
    logic signed [63:0] w_quo;
    logic signed [31:0] w_diff;
    logic signed [31:0] w_den;
    logic [31:0]        w_idx32;

    assign w_lam = (r_forget == 17'd0) ? 17'd1 : r_forget;

    always_comb begin
        if (r_ph == PH_R && r_state != S_CLEAR) begin
            w_row = r_j;
            w_col = r_i;
        end else begin
            w_row = r_i;
            w_col = r_j;
        end
        w_lin  = 32'(w_row) * NPAR + 32'(w_col);
        w_addr = w_lin[AW-1:0];
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = 32'd0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_wdata = (r_i == r_j) ? {1'b0, r_init_cov} : 32'd0;
        end else if (r_state == S_WR) begin
            w_we    = 1'b1;
            w_wdata = sat32(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_pmem[w_addr] <= w_wdata;
        end
        r_pdat <= r_pmem[w_addr];
    end

    always_comb begin
        unique case (r_ph)
            PH_EPS: begin
                w_ma = r_coef[r_j];
                w_mb = r_phi[r_j];
            end
            PH_C, PH_K: begin
                w_ma = r_pdat;
                w_mb = r_phi[r_j];
            end
            PH_R: begin
                w_ma = r_phi[r_j];
                w_mb = r_pdat;
            end
            PH_DEN: begin
                w_ma = r_r[r_j];
                w_mb = r_phi[r_j];
            end
            PH_UPD: begin
                w_ma = r_c[r_i];
                w_mb = r_r[r_j];
            end
            default: begin
                w_ma = r_pdat;
                w_mb = r_phi[r_j];
            end
        endcase
    end

    assign w_acc_n = r_acc + qround(r_prod);
    assign w_den   = sat32(w_acc_n);

    // restoring divider step
    assign w_dt   = {r_dr, r_dq[63]};
    assign w_dge  = (w_dt >= {1'b0, r_dd});
    assign w_dr_n = w_dge ? (w_dt - {1'b0, r_dd}) : w_dt;
    assign w_dq_n = {r_dq[62:0], w_dge};
    assign w_quo  = r_dneg ? -$signed(w_dq_n) : $signed(w_dq_n);
    assign w_diff = sat32(64'(r_pold) - r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ph        <= PH_EPS;
            r_i         <= '0;
            r_j         <= '0;
            r_forget    <= FORGET_RST;
            r_dead      <= DEAD_TIME_RST;
            r_init_coef <= INIT_COEF_RST;
            r_init_cov  <= INIT_COV_RST;
            r_dcnt      <= '0;
            r_dsec      <= 1'b0;
            for (int n = 0; n < IN_DEPTH; n++) r_hist_u[n] <= '0;
            for (int n = 0; n < NA; n++) r_hist_y[n] <= '0;
            for (int n = 0; n < NPAR; n++) r_coef[n] <= INIT_COEF_RST;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_j == LAST) begin
                        r_j <= '0;
                        if (r_i == LAST) begin
                            r_i     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        for (int n = IN_DEPTH - 1; n > 0; n--) r_hist_u[n] <= r_hist_u[n-1];
                        r_hist_u[0] <= i_in.u_sample;
                        r_y         <= i_in.y_sample;
                        r_state     <= S_PHI;
                    end
                end
                S_PHI: begin
                    for (int n = 0; n < NB; n++) begin
                        r_phi[n] <= r_hist_u[HW'(((int'(r_dead) > MAX_DEAD_TIME)
                                    ? MAX_DEAD_TIME : int'(r_dead)) + n)];
                    end
                    for (int n = 0; n < NA; n++) r_phi[NB+n] <= r_hist_y[n];
                    r_ph    <= PH_EPS;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_ma * w_mb;
                    r_pold  <= r_pdat;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ph == PH_UPD) begin
                        r_dneg  <= r_prod[63];
                        r_dq    <= r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
                        r_dr    <= '0;
                        r_dd    <= r_den;
                        r_dcnt  <= '0;
                        r_dsec  <= 1'b0;
                        r_state <= S_DIV;
                    end else if (r_j != LAST) begin
                        r_acc   <= w_acc_n;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_acc   <= '0;
                        r_j     <= '0;
                        r_state <= S_RD;
                        unique case (r_ph)
                            PH_EPS: begin
                                r_eps <= sat32(64'(r_y) - w_acc_n);
                                r_ph  <= PH_C;
                                r_i   <= '0;
                            end
                            PH_C: begin
                                r_c[r_i] <= w_den;
                                if (r_i == LAST) begin
                                    r_i  <= '0;
                                    r_ph <= PH_R;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end
                            PH_R: begin
                                r_r[r_i] <= w_den;
                                if (r_i == LAST) begin
                                    r_i   <= '0;
                                    r_ph  <= PH_DEN;
                                    r_acc <= 64'(w_lam);
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end
                            PH_DEN: begin
                                r_den <= (w_den <= 32'sd0) ? 32'sd1 : w_den;
                                r_ph  <= PH_UPD;
                                r_i   <= '0;
                            end
                            default: begin
                                r_k     <= w_den;
                                r_state <= S_KMUL;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_dq   <= w_dq_n;
                    r_dr   <= w_dr_n[31:0];
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd63) begin
                        r_q     <= w_quo;
                        r_state <= r_dsec ? S_WR : S_SUB;
                    end
                end
                S_SUB: begin
                    r_dneg  <= w_diff[31];
                    r_dq    <= w_diff[31] ? 64'(-{{16{w_diff[31]}}, w_diff, 16'd0})
                                          : {{16{w_diff[31]}}, w_diff, 16'd0};
                    r_dr    <= '0;
                    r_dd    <= 32'(w_lam);
                    r_dcnt  <= '0;
                    r_dsec  <= 1'b1;
                    r_state <= S_DIV;
                end
                S_WR: begin
                    r_state <= S_RD;
                    if (r_j == LAST) begin
                        r_j <= '0;
                        if (r_i == LAST) begin
                            r_i   <= '0;
                            r_ph  <= PH_K;
                            r_acc <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_KMUL: begin
                    r_prod  <= r_k * r_eps;
                    r_state <= S_KUPD;
                end
                S_KUPD: begin
                    r_coef[r_i] <= sat32(64'(r_coef[r_i]) + qround(r_prod));
                    r_acc       <= '0;
                    r_j         <= '0;
                    if (r_i == LAST) begin
                        for (int n = NA - 1; n > 0; n--) r_hist_y[n] <= r_hist_y[n-1];
                        r_hist_y[0] <= sat32(-64'(r_y));
                        r_i         <= '0;
                        r_state     <= S_EMIT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        if (r_i == LAST) begin
                            r_i     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FORGET:    r_forget <= i_cfg_wdata[16:0];
                    CFG_DEAD_TIME: r_dead   <= i_cfg_wdata[3:0];
                    CFG_INIT_COEF: begin
                        r_init_coef <= i_cfg_wdata;
                        for (int n = 0; n < NPAR; n++) r_coef[n] <= i_cfg_wdata;
                    end
                    CFG_INIT_COV: begin
                        r_init_cov <= i_cfg_wdata[30:0];
                        r_i        <= '0;
                        r_j        <= '0;
                        r_state    <= S_CLEAR;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign w_idx32     = 32'(r_i);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        o_out.coef_index = w_idx32[2:0];
        o_out.coef_value = r_coef[r_i];
        o_out.pred_error = r_eps;
        o_out.last_coef  = (r_i == LAST);
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output phases overlap");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready after accepting an item");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dd != 32'd0))
        else $error("divider started with zero divisor");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.last_coef
         && !(i_cfg_we && i_cfg_idx == CFG_INIT_COV)) |=> o_in_ready)
        else $error("not ready after last coefficient");
`endif

endmodule

`default_nettype wire
